### hw/rtl/pwm_led_fade_engine_top_macros.svh
// Assertion helpers for the checker file plfe_chk.sv.
`ifndef PWM_LED_FADE_ENGINE_TOP_MACROS_SVH
`define PWM_LED_FADE_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PLFE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plfe assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PLFE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plfe assertion failed");

`endif

### hw/rtl/plfe_pkg.sv
package plfe_pkg;

    localparam int MODE_W = 3;
    localparam int LVL_W  = 8;
    localparam int DUR_W  = 16;
    localparam int CNT_W  = 26;
    localparam int DIV_STEPS = CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [MODE_W-1:0] MODE_TICK = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FADE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ON   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OFF  = 3'd4;

    localparam logic [CNT_W-1:0] MS_PER_S = CNT_W'(1000);
    localparam logic [CNT_W-1:0] CNT_MAX  = '1;
    localparam logic [LVL_W-1:0] DUTY_ON  = LVL_W'(1);

    typedef struct packed {
        logic load;
        logic exec;
        logic div_load;
        logic div_step;
        logic commit;
        logic out_load;
    } plfe_cmd_t;

    typedef struct packed {
        logic fade_start;
        logic div_last;
        logic out_free;
    } plfe_sts_t;

endpackage

### hw/rtl/plfe_ifs.sv
interface plfe_req_if;
    import plfe_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [LVL_W-1:0]  level;
    logic [DUR_W-1:0]  duration_s;

    modport source (output valid, output mode, output level, output duration_s, input ready);
    modport sink   (input valid, input mode, input level, input duration_s, output ready);
endinterface

interface plfe_rsp_if;
    import plfe_pkg::*;

    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] pwm_duty;
    logic [LVL_W-1:0] brightness;
    logic             fading;

    modport source (output valid, output pwm_duty, output brightness, output fading, input ready);
    modport sink   (input valid, input pwm_duty, input brightness, input fading, output ready);
endinterface

### hw/rtl/plfe_div.sv
module plfe_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic                       step,
    input  logic [plfe_pkg::CNT_W-1:0] dividend,
    input  logic [plfe_pkg::LVL_W-1:0] divisor,
    output logic [plfe_pkg::CNT_W-1:0] quotient,
    output logic                       last
);
    import plfe_pkg::*;

    logic [CNT_W-1:0]     dvd_reg, dvd_next;
    logic [LVL_W-1:0]     rem_reg, rem_next;
    logic [LVL_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [LVL_W:0]       trial;
    logic [LVL_W:0]       diff;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[CNT_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = '0;
        end
        else if (step)
        begin
            dvd_next = {dvd_reg[CNT_W-2:0], fits};
            rem_next = fits ? diff[LVL_W-1:0] : trial[LVL_W-1:0];
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = dvd_reg;
    assign last     = cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);

endmodule

### hw/rtl/plfe_dp.sv
module plfe_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  plfe_pkg::plfe_cmd_t         cmd,
    output plfe_pkg::plfe_sts_t         sts,
    input  logic [plfe_pkg::MODE_W-1:0] in_mode,
    input  logic [plfe_pkg::LVL_W-1:0]  in_level,
    input  logic [plfe_pkg::DUR_W-1:0]  in_duration_s,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [plfe_pkg::LVL_W-1:0]  out_pwm_duty,
    output logic [plfe_pkg::LVL_W-1:0]  out_brightness,
    output logic                        out_fading
);
    import plfe_pkg::*;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [LVL_W-1:0]  tgt_in_reg, tgt_in_next;
    logic [DUR_W-1:0]  dur_reg, dur_next;
    logic [LVL_W-1:0]  diff_reg, diff_next;
    logic [CNT_W-1:0]  prod_reg, prod_next;

    logic [LVL_W-1:0]  level_reg, level_next;
    logic [LVL_W-1:0]  duty_reg, duty_next;
    logic              fade_on_reg, fade_on_next;
    logic              fade_down_reg, fade_down_next;
    logic [LVL_W-1:0]  target_reg, target_next;
    logic [CNT_W-1:0]  interval_reg, interval_next;
    logic [CNT_W-1:0]  elapsed_reg, elapsed_next;

    logic              out_valid_reg, out_valid_next;
    logic [LVL_W-1:0]  out_duty_reg, out_duty_next;
    logic [LVL_W-1:0]  out_level_reg, out_level_next;
    logic              out_fading_reg, out_fading_next;

    logic [CNT_W-1:0]  el_inc;
    logic [LVL_W-1:0]  step_level;
    logic [CNT_W-1:0]  quotient;
    logic              div_last;

    plfe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (prod_reg),
        .divisor  (diff_reg),
        .quotient (quotient),
        .last     (div_last)
    );

    assign el_inc     = (elapsed_reg == CNT_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign step_level = fade_down_reg ? level_reg - 1'b1 : level_reg + 1'b1;

    always_comb
    begin
        mode_next       = mode_reg;
        tgt_in_next     = tgt_in_reg;
        dur_next        = dur_reg;
        diff_next       = diff_reg;
        prod_next       = prod_reg;
        level_next      = level_reg;
        duty_next       = duty_reg;
        fade_on_next    = fade_on_reg;
        fade_down_next  = fade_down_reg;
        target_next     = target_reg;
        interval_next   = interval_reg;
        elapsed_next    = elapsed_reg;
        out_valid_next  = out_valid_reg;
        out_duty_next   = out_duty_reg;
        out_level_next  = out_level_reg;
        out_fading_next = out_fading_reg;

        if (cmd.load)
        begin
            mode_next   = in_mode;
            tgt_in_next = in_level;
            dur_next    = in_duration_s;
        end

        if (cmd.exec)
        begin
            unique case (mode_reg)
                MODE_TICK:
                begin
                    if (fade_on_reg)
                    begin
                        if (el_inc > interval_reg)
                        begin
                            level_next   = step_level;
                            duty_next    = step_level;
                            elapsed_next = '0;
                            if (step_level == target_reg)
                            begin
                                fade_on_next = 1'b0;
                            end
                        end
                        else
                        begin
                            elapsed_next = el_inc;
                        end
                    end
                end
                MODE_SET:
                begin
                    level_next = tgt_in_reg;
                    duty_next  = tgt_in_reg;
                end
                MODE_FADE:
                begin
                    if (tgt_in_reg != level_reg)
                    begin
                        fade_down_next = level_reg > tgt_in_reg;
                        diff_next      = (level_reg > tgt_in_reg) ? level_reg - tgt_in_reg
                                                                  : tgt_in_reg - level_reg;
                        prod_next      = CNT_W'(dur_reg) * MS_PER_S;
                    end
                end
                MODE_ON:
                begin
                    if (level_reg == '0)
                    begin
                        duty_next = DUTY_ON;
                    end
                end
                MODE_OFF:
                begin
                    duty_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.commit)
        begin
            interval_next = quotient;
            target_next   = tgt_in_reg;
            elapsed_next  = '0;
            fade_on_next  = 1'b1;
        end

        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_duty_next   = duty_reg;
            out_level_next  = level_reg;
            out_fading_next = fade_on_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            duty_reg      <= '0;
            fade_on_reg   <= 1'b0;
            fade_down_reg <= 1'b0;
            target_reg    <= '0;
            interval_reg  <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            duty_reg      <= duty_next;
            fade_on_reg   <= fade_on_next;
            fade_down_reg <= fade_down_next;
            target_reg    <= target_next;
            interval_reg  <= interval_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        tgt_in_reg     <= tgt_in_next;
        dur_reg        <= dur_next;
        diff_reg       <= diff_next;
        prod_reg       <= prod_next;
        out_duty_reg   <= out_duty_next;
        out_level_reg  <= out_level_next;
        out_fading_reg <= out_fading_next;
    end

    assign sts.fade_start = (mode_reg == MODE_FADE) && (tgt_in_reg != level_reg);
    assign sts.div_last   = div_last;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign out_pwm_duty   = out_duty_reg;
    assign out_brightness = out_level_reg;
    assign out_fading     = out_fading_reg;

endmodule

### hw/rtl/plfe_ctrl.sv
module plfe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  plfe_pkg::plfe_sts_t sts,
    output plfe_pkg::plfe_cmd_t cmd
);
    import plfe_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV_LOAD,
        ST_DIV,
        ST_COMMIT,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_EXEC;
                        ready_reg <= 1'b0;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= sts.fade_start ? ST_DIV_LOAD : ST_DONE;
                end
                ST_DIV_LOAD:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (sts.div_last)
                    begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:     cmd.load     = in_valid;
            ST_EXEC:     cmd.exec     = 1'b1;
            ST_DIV_LOAD: cmd.div_load = 1'b1;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_COMMIT:   cmd.commit   = 1'b1;
            ST_DONE:     cmd.out_load = sts.out_free;
            default:     cmd          = '0;
        endcase
    end

    assign in_ready = ready_reg;

endmodule

### hw/rtl/pwm_led_fade_engine_top.sv
// LED fade engine: one request (tick, set, fade, on, off, unused) yields one
// response with the duty, the stored brightness and the fade flag after it.
// Tick, set, on, off and unused codes pass the execute and done states; a fade
// start that changes the level also passes divider load, the 26-step restoring
// divider that forms duration_s*1000 / level difference one quotient bit per
// cycle, and commit. A finished response waits in the output register, so the
// next request is accepted while it is still pending.
module pwm_led_fade_engine_top (
    input  logic        clk,
    input  logic        rst_n,
    plfe_req_if.sink    req,
    plfe_rsp_if.source  rsp
);
    import plfe_pkg::*;

    plfe_cmd_t cmd;
    plfe_sts_t sts;

    plfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    plfe_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_mode        (req.mode),
        .in_level       (req.level),
        .in_duration_s  (req.duration_s),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .out_pwm_duty   (rsp.pwm_duty),
        .out_brightness (rsp.brightness),
        .out_fading     (rsp.fading)
    );

endmodule

### hw/rtl/plfe_chk.sv
`include "pwm_led_fade_engine_top_macros.svh"

module plfe_chk (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready
);
    logic [1:0] pend_reg, pend_next;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_comb
    begin
        pend_next = pend_reg + {1'b0, req_acc} - {1'b0, rsp_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `PLFE_ASSERT_NXT(a_busy_after_req, req_acc, !req_ready)
    `PLFE_ASSERT_IMP(a_rsp_has_req, rsp_valid, pend_reg != 2'd0)
    `PLFE_ASSERT_IMP(a_pend_bound, 1'b1, pend_reg != 2'd3)
    `PLFE_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind pwm_led_fade_engine_top plfe_chk u_plfe_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
);

### dv/pwm_led_fade_engine_top_test.sv
module pwm_led_fade_engine_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import plfe_pkg::*;

    localparam logic [MODE_W-1:0] MODE_RSVD_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD_HI  = 3'd7;

    localparam int RANDOM_ITEMS = 1500;
    localparam int CALM_ITEMS   = 1300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [LVL_W-1:0] duty;
        logic [LVL_W-1:0] brightness;
        logic             fading;
    } lamp_rsp_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LVL_W-1:0]  level;
        logic [DUR_W-1:0]  duration_s;
        logic              typed;
        lamp_rsp_t         rsp;
    } fade_req_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    plfe_req_if req_if();
    plfe_rsp_if rsp_if();

    pwm_led_fade_engine_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #5 clk = ~clk;

    logic [LVL_W-1:0] lvl_now       = '0;
    logic [LVL_W-1:0] duty_now      = '0;
    logic [LVL_W-1:0] target_now    = '0;
    logic             fade_on_now   = 1'b0;
    logic             fade_down_now = 1'b0;
    logic [CNT_W-1:0] interval_now  = '0;
    logic [CNT_W-1:0] elapsed_now   = '0;

    lamp_rsp_t lamp_expected_q[$];

    bit idling_on   = 1'b1;
    int work_items  = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    fade_req_row_t directed_rows [25] = '{
        '{MODE_TICK,     8'd0,   16'd0,      1'b1, '{8'd0,   8'd0,   1'b0}},
        '{MODE_SET,      8'd255, 16'd0,      1'b1, '{8'd255, 8'd255, 1'b0}},
        '{MODE_OFF,      8'd0,   16'd0,      1'b1, '{8'd0,   8'd255, 1'b0}},
        '{MODE_ON,       8'd0,   16'd0,      1'b1, '{8'd0,   8'd255, 1'b0}},
        '{MODE_SET,      8'd0,   16'd0,      1'b1, '{8'd0,   8'd0,   1'b0}},
        '{MODE_ON,       8'd0,   16'd0,      1'b1, '{8'd1,   8'd0,   1'b0}},
        '{MODE_FADE,     8'd0,   16'hFFFF,   1'b1, '{8'd1,   8'd0,   1'b0}},
        '{MODE_RSVD_LO,  8'hAA,  16'h5555,   1'b1, '{8'd1,   8'd0,   1'b0}},
        '{MODE_RSVD_MID, 8'h55,  16'hAAAA,   1'b1, '{8'd1,   8'd0,   1'b0}},
        '{MODE_RSVD_HI,  8'hFF,  16'hFFFF,   1'b1, '{8'd1,   8'd0,   1'b0}},
        '{MODE_FADE,     8'd255, 16'd0,      1'b1, '{8'd1,   8'd0,   1'b1}},
        '{MODE_TICK,     8'd0,   16'd0,      1'b0, '0},
        '{MODE_TICK,     8'd0,   16'd0,      1'b0, '0},
        '{MODE_FADE,     8'd4,   16'd0,      1'b0, '0},
        '{MODE_TICK,     8'd0,   16'd0,      1'b0, '0},
        '{MODE_TICK,     8'd0,   16'd0,      1'b0, '0},
        '{MODE_SET,      8'd255, 16'd0,      1'b0, '0},
        '{MODE_FADE,     8'd0,   16'hFFFF,   1'b0, '0},
        '{MODE_FADE,     8'd128, 16'hFFFF,   1'b0, '0},
        '{MODE_SET,      8'd1,   16'd0,      1'b0, '0},
        '{MODE_FADE,     8'd0,   16'd1,      1'b0, '0},
        '{MODE_SET,      8'd3,   16'd0,      1'b0, '0},
        '{MODE_FADE,     8'd0,   16'd0,      1'b0, '0},
        '{MODE_TICK,     8'd0,   16'd0,      1'b0, '0},
        '{MODE_TICK,     8'd0,   16'd0,      1'b0, '0}
    };

    function automatic lamp_rsp_t advance_lamp(
        input logic [MODE_W-1:0] mode,
        input logic [LVL_W-1:0]  lvl,
        input logic [DUR_W-1:0]  dur
    );
        logic [31:0]      span;
        logic [LVL_W-1:0] diff;
        case (mode)
            MODE_TICK:
            begin
                if (fade_on_now)
                begin
                    if (elapsed_now != CNT_MAX)
                        elapsed_now = elapsed_now + 1'b1;
                    if (elapsed_now > interval_now)
                    begin
                        lvl_now = fade_down_now ? lvl_now - 1'b1 : lvl_now + 1'b1;
                        duty_now = lvl_now;
                        elapsed_now = '0;
                        if (lvl_now == target_now)
                            fade_on_now = 1'b0;
                    end
                end
            end
            MODE_SET:
            begin
                lvl_now = lvl;
                duty_now = lvl;
            end
            MODE_FADE:
            begin
                if (lvl != lvl_now)
                begin
                    fade_down_now = lvl_now > lvl;
                    diff = fade_down_now ? lvl_now - lvl : lvl - lvl_now;
                    span = 32'(dur) * 32'(MS_PER_S);
                    interval_now = CNT_W'(span / 32'(diff));
                    target_now = lvl;
                    elapsed_now = '0;
                    fade_on_now = 1'b1;
                end
            end
            MODE_ON:
            begin
                if (lvl_now == '0)
                    duty_now = DUTY_ON;
            end
            MODE_OFF:
            begin
                duty_now = '0;
            end
            default:
            begin
            end
        endcase
        return '{duty_now, lvl_now, fade_on_now};
    endfunction

    task automatic send_request(
        input logic [MODE_W-1:0] mode,
        input logic [LVL_W-1:0]  lvl,
        input logic [DUR_W-1:0]  dur,
        input logic              typed,
        input lamp_rsp_t         typed_rsp
    );
        lamp_rsp_t predicted;
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.mode       <= mode;
        req_if.level      <= lvl;
        req_if.duration_s <= dur;
        do
            @(posedge clk);
        while (!req_if.ready);
        if (mode < MODE_RSVD_LO && !(mode == MODE_TICK && !fade_on_now))
            work_items++;
        predicted = advance_lamp(mode, lvl, dur);
        lamp_expected_q.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (lamp_expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_noise();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 88)
            send_request(MODE_TICK, LVL_W'($urandom), DUR_W'($urandom), 1'b0, '0);
        else if (pick < 92)
            send_request(MODE_SET, LVL_W'($urandom), DUR_W'($urandom), 1'b0, '0);
        else if (pick < 95)
            send_request(MODE_ON, LVL_W'($urandom), DUR_W'($urandom), 1'b0, '0);
        else if (pick < 98)
            send_request(MODE_OFF, LVL_W'($urandom), DUR_W'($urandom), 1'b0, '0);
        else
            send_request(MODE_W'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI)),
                         LVL_W'($urandom), DUR_W'($urandom), 1'b0, '0);
    endtask

    task automatic run_fade_sequence();
        logic [LVL_W-1:0] tgt;
        logic [DUR_W-1:0] dur;
        int pick;
        tgt = ($urandom_range(0, 19) == 0) ? lvl_now : LVL_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60)
            dur = '0;
        else if (pick < 85)
            dur = DUR_W'(1);
        else if (pick < 95)
            dur = DUR_W'($urandom_range(2, 4));
        else
            dur = DUR_W'($urandom);
        send_request(MODE_FADE, tgt, dur, 1'b0, '0);
        repeat ($urandom_range(0, 48))
            send_noise();
    endtask

    initial
    begin
        req_if.valid      <= 1'b0;
        req_if.mode       <= MODE_TICK;
        req_if.level      <= '0;
        req_if.duration_s <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].mode, directed_rows[i].level,
                         directed_rows[i].duration_s, directed_rows[i].typed,
                         directed_rows[i].rsp);

        wait_for_drain();
        work_items = 0;

        while (work_items < RANDOM_ITEMS)
        begin
            if (work_items > CALM_ITEMS)
                idling_on = 1'b0;
            if ($urandom_range(0, 49) == 0)
                wait_for_drain();
            run_fade_sequence();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && lamp_expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rsp_if.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (idling_on && $urandom_range(0, 5) == 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        lamp_rsp_t want;
        lamp_rsp_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = '{rsp_if.pwm_duty, rsp_if.brightness, rsp_if.fading};
            if (lamp_expected_q.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: response with none pending: duty %0d bright %0d fading %0b",
                             $realtime, got.duty, got.brightness, got.fading);
            end
            else
            begin
                want = lamp_expected_q.pop_front();
                if (got.duty != want.duty || got.brightness != want.brightness ||
                    got.fading != want.fading)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: duty %0d/%0d bright %0d/%0d fading %0b/%0b (exp/act)",
                                 $realtime, want.duty, got.duty, want.brightness,
                                 got.brightness, want.fading, got.fading);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
